// ===== rtl/tpps_pkg.sv =====
// ----------------------------------------------------------------------------
// tpps_pkg: shared types and constants of the three plane pixel store
// Holds the payload structs, command and register codes and fixed widths.
// ----------------------------------------------------------------------------
package tpps_pkg;

    localparam int unsigned MAX_PIXELS_DEFAULT = 65536;

    // Computed address: 511 * 1023 + 511 fits in 20 bits.
    localparam int unsigned PIX_ADDR_W = 20;

    localparam logic [9:0] WIDTH_RESET  = 10'd320;
    localparam logic [9:0] HEIGHT_RESET = 10'd200;

    localparam logic [7:0] NIB_HI_MASK = 8'hF0;
    localparam logic [7:0] NIB_LO_MASK = 8'h0F;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_READ   = 2'd1,
        CMD_FILL   = 2'd2,
        CMD_DITHER = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_t       command;
        logic [8:0] pos_x;
        logic [8:0] pos_y;
        logic [2:0] plane_mask;
        logic [7:0] color_value;
        logic [7:0] priority_value;
        logic [7:0] control_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] visual_out;
        logic [7:0] priority_out;
        logic [7:0] control_out;
        logic [2:0] match_mask;
        logic       out_of_range;
    } out_item_t;

    typedef struct packed {
        logic [7:0] vis;
        logic [7:0] pri;
        logic [7:0] con;
    } plane_word_t;

    // One classified job as it waits between front and back.
    typedef struct packed {
        cmd_t                  command;
        logic [PIX_ADDR_W-1:0] addr;
        logic                  parity;
        logic                  out_of_range;
        logic [2:0]            plane_mask;
        plane_word_t           value;
    } job_t;

endpackage

// ===== rtl/tpps_if.sv =====
// ----------------------------------------------------------------------------
// tpps_if: valid/ready channels of the three plane pixel store
// One interface for the command channel and one for the result channel.
// ----------------------------------------------------------------------------
interface tpps_in_if;
    import tpps_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpps_out_if;
    import tpps_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/three_plane_pixel_store_top.sv =====
// ----------------------------------------------------------------------------
// three_plane_pixel_store_top: visual, priority and control pixel planes
// Put, read, fill-match and dither commands on a y*width+x addressed store.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Carries
//  in_ch     sink       valid/ready        one command transaction
//  out_ch    source     valid/ready        one result transaction
//  cfg       input      cfg_we (no wait)   screen_width, screen_height
//
// Each command passes through two back end states: BK_IDLE pops it and reads
// the pixel word from the single-port plane memory, and BK_EXEC modifies and
// writes it back; the back end takes no new job until that write-back is done.
// Out of range commands skip the memory and BK_EXEC. After reset a clearing
// pass writes zero to all MAX_PIXELS words, one per cycle, and in_ch.ready
// stays low until that pass is over. The two entry queue and the output
// register let commands be taken while a result waits on out_ch.
//
module three_plane_pixel_store_top #(
    parameter int unsigned MAX_PIXELS = tpps_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  tpps_pkg::cfg_reg_t cfg_index,
    input  logic [9:0]         cfg_data,
    tpps_in_if.sink            in_ch,
    tpps_out_if.source         out_ch
);
    import tpps_pkg::*;

    // Front to queue.
    logic push;
    job_t push_data;
    logic queue_full;

    // Queue to back.
    job_t head;
    logic empty;
    logic pop;

    // The back end holds off new commands while it clears the planes.
    logic clear_busy;

    // The front checks the coordinate against the screen size and the
    // memory depth and forms the linear address before the job is queued.
    tpps_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .clear_busy (clear_busy),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    tpps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // The back end owns the plane memory; a job is popped only when the
    // output register will be free to take its result.
    tpps_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_ch     (out_ch)
    );

endmodule

// ===== rtl/tpps_queue.sv =====
// ----------------------------------------------------------------------------
// tpps_queue: two entry job queue
// Decouples the classifying front from the memory back end.
// ----------------------------------------------------------------------------
module tpps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpps_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output tpps_pkg::job_t head,
    output logic           empty
);
    import tpps_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/tpps_front.sv =====
// ----------------------------------------------------------------------------
// tpps_front: command intake and classification
// Holds the screen size registers, forms the pixel address and range flag.
// ----------------------------------------------------------------------------
module tpps_front #(
    parameter int unsigned MAX_PIXELS = tpps_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  tpps_pkg::cfg_reg_t cfg_index,
    input  logic [9:0]         cfg_data,
    tpps_in_if.sink            in_ch,
    input  logic               clear_busy,
    input  logic               queue_full,
    output logic               push,
    output tpps_pkg::job_t     push_data
);
    import tpps_pkg::*;

    logic [9:0]            width_reg;
    logic [9:0]            height_reg;
    logic [18:0]           row_base;
    logic [PIX_ADDR_W-1:0] addr;
    logic                  oor;

    assign in_ch.ready = !queue_full && !clear_busy;
    assign push        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        row_base = {10'd0, in_ch.data.pos_y} * {9'd0, width_reg};
        addr     = {1'b0, row_base} + {11'd0, in_ch.data.pos_x};
        oor      = ({1'b0, in_ch.data.pos_x} >= width_reg)
                || ({1'b0, in_ch.data.pos_y} >= height_reg)
                || ({1'b0, addr} >= (PIX_ADDR_W + 1)'(MAX_PIXELS));

        push_data.command      = in_ch.data.command;
        push_data.addr         = addr;
        push_data.parity       = in_ch.data.pos_x[0] ^ in_ch.data.pos_y[0];
        push_data.out_of_range = oor;
        push_data.plane_mask   = in_ch.data.plane_mask;
        push_data.value.vis    = in_ch.data.color_value;
        push_data.value.pri    = in_ch.data.priority_value;
        push_data.value.con    = in_ch.data.control_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tpps_back.sv =====
// ----------------------------------------------------------------------------
// tpps_back: plane memory and command execution
// Clears the planes after reset, then runs read-modify-write per in-range job.
// ----------------------------------------------------------------------------
module tpps_back #(
    parameter int unsigned MAX_PIXELS = tpps_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tpps_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           clear_busy,
    tpps_out_if.source     out_ch
);
    import tpps_pkg::*;

    localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    plane_word_t mem [MAX_PIXELS];

    back_state_t state_reg;
    back_state_t state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    job_t        job_reg;
    plane_word_t rd_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;

    logic        out_free;
    logic        mem_re;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    plane_word_t mem_wdata;
    plane_word_t new_word;
    logic [2:0]  match;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
    assign clear_busy   = (state_reg == BK_CLEAR);

    // New pixel word from the value read and the job.
    always_comb
    begin
        new_word = rd_data_reg;
        match    = 3'b000;
        case (job_reg.command)
            CMD_PUT:
            begin
                if (job_reg.plane_mask[0]) new_word.vis = job_reg.value.vis;
                if (job_reg.plane_mask[1]) new_word.pri = job_reg.value.pri;
                if (job_reg.plane_mask[2]) new_word.con = job_reg.value.con;
            end
            CMD_FILL:
            begin
                match[0] = job_reg.plane_mask[0] && (rd_data_reg.vis == job_reg.value.vis);
                match[1] = job_reg.plane_mask[1] && (rd_data_reg.pri == job_reg.value.pri);
                match[2] = job_reg.plane_mask[2] && (rd_data_reg.con == job_reg.value.con);
            end
            CMD_DITHER:
            begin
                if ((rd_data_reg.vis & NIB_HI_MASK) != 8'd0)
                begin
                    if (job_reg.parity)
                    begin
                        new_word.vis = {4'd0, rd_data_reg.vis[7:4] ^ rd_data_reg.vis[3:0]};
                    end
                    else
                    begin
                        new_word.vis = rd_data_reg.vis & NIB_LO_MASK;
                    end
                end
            end
            default:
            begin
                new_word = rd_data_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pop            = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = job_reg.addr[AW-1:0];
        mem_wdata      = new_word;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_PIXELS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop = 1'b1;
                    if (head.out_of_range)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_data_next.out_of_range = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = BK_EXEC;
                    end
                end
            end
            BK_EXEC:
            begin
                mem_we         = 1'b1;
                out_valid_next = 1'b1;
                out_data_next.visual_out   = new_word.vis;
                out_data_next.priority_out = new_word.pri;
                out_data_next.control_out  = new_word.con;
                out_data_next.match_mask   = match;
                out_data_next.out_of_range = 1'b0;
                state_next     = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (pop)
        begin
            job_reg <= head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[head.addr[AW-1:0]];
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the three plane pixel store
// Drives put, read, fill-match and dither transactions into the store over
// several screen sizes and idle patterns. A model of the three planes in the
// bench predicts every result, and a checker compares each one on arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import tpps_pkg::*;

    // Clock period in ns and the overall run limit in clock cycles. The
    // limit covers the clearing pass after reset (one pixel per cycle), the
    // slowest idle mixes and a wide margin on top.
    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 800_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 40;

    localparam int unsigned PIXELS = MAX_PIXELS_DEFAULT;

    // Bit positions of the planes in plane_mask and match_mask.
    localparam int VIS_BIT = 0;
    localparam int PRI_BIT = 1;
    localparam int CON_BIT = 2;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_reg_t   cfg_index;
    logic [9:0] cfg_data;

    tpps_in_if  in_ch ();
    tpps_out_if out_ch ();

    three_plane_pixel_store_top #(
        .MAX_PIXELS (PIXELS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Bench copy of the three planes and the two screen registers. They are
    // updated at the moment a command transaction is accepted, so the
    // predicted results come out in the same order as the store serves them.
    logic [7:0]  pix_visual   [PIXELS];
    logic [7:0]  pix_priority [PIXELS];
    logic [7:0]  pix_control  [PIXELS];
    int unsigned cfg_width;
    int unsigned cfg_height;

    // Results still owed by the store, oldest first.
    out_item_t   expected_pixels [$];

    // Idle controls, changed per traffic phase.
    int unsigned send_idle_pct;
    int unsigned result_stall_pct;

    // Bookkeeping for the error count and the closing summary.
    int n_errors;
    int results_checked;
    int jobs_sent;
    int cmd_count [4];
    int n_out_of_range;
    int n_matched;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Works out the linear pixel address and tells whether the pixel lies
    // inside the configured screen and inside the plane memory.
    function automatic bit locate_pixel(input logic [8:0] x, input logic [8:0] y,
                                        output int unsigned addr);
        int unsigned ux;
        int unsigned uy;
        ux   = 32'(x);
        uy   = 32'(y);
        addr = uy * cfg_width + ux;
        return (ux < cfg_width) && (uy < cfg_height) && (addr < PIXELS);
    endfunction

    // Applies one command to the bench planes and returns the result that
    // the store must produce for it.
    function automatic out_item_t apply_pixel_job(input in_item_t job);
        out_item_t   res;
        int unsigned addr;
        logic [7:0]  old_vis;
        res = '0;
        if (!locate_pixel(job.pos_x, job.pos_y, addr))
        begin
            res.out_of_range = 1'b1;
            return res;
        end
        case (job.command)
            CMD_PUT:
            begin
                if (job.plane_mask[VIS_BIT])
                    pix_visual[addr] = job.color_value;
                if (job.plane_mask[PRI_BIT])
                    pix_priority[addr] = job.priority_value;
                if (job.plane_mask[CON_BIT])
                    pix_control[addr] = job.control_value;
            end
            CMD_FILL:
            begin
                res.match_mask[VIS_BIT] = job.plane_mask[VIS_BIT] &&
                                          (pix_visual[addr] == job.color_value);
                res.match_mask[PRI_BIT] = job.plane_mask[PRI_BIT] &&
                                          (pix_priority[addr] == job.priority_value);
                res.match_mask[CON_BIT] = job.plane_mask[CON_BIT] &&
                                          (pix_control[addr] == job.control_value);
            end
            CMD_DITHER:
            begin
                // Bytes with an empty high nibble are left alone.
                old_vis = pix_visual[addr];
                if ((old_vis & NIB_HI_MASK) != 8'h00)
                begin
                    if (job.pos_x[0] ^ job.pos_y[0])
                        pix_visual[addr] = (old_vis >> 4) ^ (old_vis & NIB_LO_MASK);
                    else
                        pix_visual[addr] = old_vis & NIB_LO_MASK;
                end
            end
            default:
            begin
            end
        endcase
        res.visual_out   = pix_visual[addr];
        res.priority_out = pix_priority[addr];
        res.control_out  = pix_control[addr];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      results_checked, name, got, want));
    endtask

    task automatic check_pixel_result(input out_item_t got);
        out_item_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("result transaction %h with nothing expected", got));
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("visual_out",   got.visual_out,   want.visual_out);
        compare_field("priority_out", got.priority_out, want.priority_out);
        compare_field("control_out",  got.control_out,  want.control_out);
        compare_field("match_mask",   {5'd0, got.match_mask}, {5'd0, want.match_mask});
        compare_field("out_of_range", {7'd0, got.out_of_range},
                      {7'd0, want.out_of_range});
        if (want.out_of_range)
            n_out_of_range++;
        if (want.match_mask != 3'b000)
            n_matched++;
        results_checked++;
    endtask

    // The result side: a result transaction is taken at an edge where valid
    // and ready are both high, and ready for the next edge is rolled against
    // the stall percentage of the current phase.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_pixel_result(out_ch.data);
        out_ch.ready <= ($urandom_range(99) >= result_stall_pct);
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offers one command transaction, after a random number of idle cycles,
    // and holds it until the store takes it. The expected result is worked
    // out at the accepting edge. The task returns in that same time step
    // with valid still high, so the caller either sends again or drains.
    task automatic send_pixel_job(input in_item_t job);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= job;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_pixels.push_back(apply_pixel_job(job));
        jobs_sent++;
        cmd_count[job.command]++;
    endtask

    // Stops offering commands and waits until every owed result has come,
    // then lets the pipeline settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write. Only called while the store is idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_WIDTH)
            cfg_width = 32'(value);
        else
            cfg_height = 32'(value);
    endtask

    task automatic set_screen(input logic [9:0] w, input logic [9:0] h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    function automatic in_item_t pixel_job(input cmd_t c, input logic [8:0] x,
                                           input logic [8:0] y, input logic [2:0] m,
                                           input logic [7:0] cv, input logic [7:0] pv,
                                           input logic [7:0] kv);
        in_item_t job;
        job.command        = c;
        job.pos_x          = x;
        job.pos_y          = y;
        job.plane_mask     = m;
        job.color_value    = cv;
        job.priority_value = pv;
        job.control_value  = kv;
        return job;
    endfunction

    // Random command with coordinates aimed mostly at a small patch in the
    // top left corner, so that later reads, probes and dithers land on
    // pixels written earlier. The rest goes anywhere in the 9 bit range or
    // right at the screen border. Fill probes usually carry the bytes that
    // the pixel holds, sometimes with one plane spoiled.
    function automatic in_item_t make_pixel_job();
        in_item_t    job;
        int unsigned pick;
        int unsigned hot_w;
        int unsigned hot_h;
        int unsigned rim;
        int unsigned addr;
        job.command        = cmd_t'($urandom_range(3));
        job.plane_mask     = 3'($urandom_range(7));
        job.color_value    = 8'($urandom_range(255));
        job.priority_value = 8'($urandom_range(255));
        job.control_value  = 8'($urandom_range(255));
        hot_w = (cfg_width == 0 || cfg_width > 16) ? 16 : cfg_width;
        hot_h = (cfg_height == 0 || cfg_height > 16) ? 16 : cfg_height;
        job.pos_x = 9'($urandom_range(hot_w - 1));
        job.pos_y = 9'($urandom_range(hot_h - 1));
        pick = $urandom_range(99);
        if (pick >= 65 && pick < 85)
        begin
            job.pos_x = 9'($urandom_range(511));
            job.pos_y = 9'($urandom_range(511));
        end
        else if (pick >= 85 && pick < 93)
        begin
            rim = (cfg_width == 0) ? $urandom_range(1) : cfg_width - 1 + $urandom_range(1);
            job.pos_x = (rim > 511) ? 9'd511 : 9'(rim);
        end
        else if (pick >= 93)
        begin
            rim = (cfg_height == 0) ? $urandom_range(1) : cfg_height - 1 + $urandom_range(1);
            job.pos_y = (rim > 511) ? 9'd511 : 9'(rim);
        end
        if (job.command == CMD_FILL && locate_pixel(job.pos_x, job.pos_y, addr) &&
            $urandom_range(99) < 70)
        begin
            job.color_value    = pix_visual[addr];
            job.priority_value = pix_priority[addr];
            job.control_value  = pix_control[addr];
            if ($urandom_range(1) == 1)
            begin
                case ($urandom_range(2))
                    0: job.color_value    = 8'($urandom_range(255));
                    1: job.priority_value = 8'($urandom_range(255));
                    default: job.control_value = 8'($urandom_range(255));
                endcase
            end
        end
        return job;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset screen of 320 by 200 with cleared planes: a read of a cleared
    // pixel, a probe of the far corner that matches zero on all planes, and
    // commands just past the right and bottom borders.
    task automatic test_reset_defaults();
        send_pixel_job(pixel_job(CMD_READ,   9'd0,   9'd0,   3'd7, 8'h5A, 8'h5A, 8'h5A));
        send_pixel_job(pixel_job(CMD_FILL,   9'd319, 9'd199, 3'd7, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_READ,   9'd320, 9'd0,   3'd7, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_DITHER, 9'd0,   9'd200, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        drain_results();
    endtask

    // Every command on three pixels: full and empty plane masks, one
    // plane at a time, partial probes where an unselected plane would match,
    // dither on both parities and on a byte with an empty high nibble.
    task automatic test_plane_ops();
        send_pixel_job(pixel_job(CMD_PUT,    9'd5,   9'd3,   3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_pixel_job(pixel_job(CMD_PUT,    9'd5,   9'd3,   3'd0, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_READ,   9'd5,   9'd3,   3'd0, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_PUT,    9'd5,   9'd3,   3'd1, 8'hA5, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_PUT,    9'd5,   9'd3,   3'd2, 8'h00, 8'h3C, 8'h00));
        send_pixel_job(pixel_job(CMD_PUT,    9'd5,   9'd3,   3'd4, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_FILL,   9'd5,   9'd3,   3'd7, 8'hA5, 8'h3C, 8'h00));
        send_pixel_job(pixel_job(CMD_FILL,   9'd5,   9'd3,   3'd5, 8'hA5, 8'h3C, 8'h01));
        send_pixel_job(pixel_job(CMD_FILL,   9'd5,   9'd3,   3'd2, 8'h00, 8'h00, 8'h00));
        // Even parity keeps the low nibble; the second dither sees an empty
        // high nibble and must leave the byte alone.
        send_pixel_job(pixel_job(CMD_DITHER, 9'd5,   9'd3,   3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_pixel_job(pixel_job(CMD_DITHER, 9'd5,   9'd3,   3'd0, 8'h00, 8'h00, 8'h00));
        // Odd parity folds the nibbles together.
        send_pixel_job(pixel_job(CMD_PUT,    9'd4,   9'd3,   3'd1, 8'hC7, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_DITHER, 9'd4,   9'd3,   3'd0, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_PUT,    9'd319, 9'd199, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_pixel_job(pixel_job(CMD_FILL,   9'd319, 9'd199, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        drain_results();
    endtask

    // Register extremes: a 512 wide screen whose last in-memory row ends on
    // the last word of the planes, zero width and zero height that put every
    // pixel out of range, and the widest stride where a pixel inside the
    // screen still falls beyond the memory.
    task automatic test_screen_geometry();
        set_screen(10'd512, 10'd512);
        send_pixel_job(pixel_job(CMD_PUT,  9'd511, 9'd127, 3'd7, 8'h11, 8'h22, 8'h33));
        send_pixel_job(pixel_job(CMD_READ, 9'd511, 9'd127, 3'd0, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_PUT,  9'd0,   9'd128, 3'd7, 8'h44, 8'h55, 8'h66));
        drain_results();
        set_screen(10'd0, 10'd200);
        send_pixel_job(pixel_job(CMD_READ, 9'd0, 9'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        drain_results();
        set_screen(10'd1, 10'd0);
        send_pixel_job(pixel_job(CMD_READ, 9'd0, 9'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        drain_results();
        set_screen(10'd1023, 10'd1023);
        send_pixel_job(pixel_job(CMD_PUT,  9'd0,   9'd64, 3'd7, 8'h5A, 8'h6B, 8'h7C));
        send_pixel_job(pixel_job(CMD_READ, 9'd0,   9'd64, 3'd0, 8'h00, 8'h00, 8'h00));
        send_pixel_job(pixel_job(CMD_READ, 9'd511, 9'd64, 3'd0, 8'h00, 8'h00, 8'h00));
        drain_results();
    endtask

    // One phase of random traffic on a given screen with given idle rates.
    // With hold_midway set, the command side stops halfway through and waits
    // for the store to empty before it carries on.
    task automatic run_traffic_phase(input logic [9:0] w, input logic [9:0] h,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int count, input bit hold_midway);
        set_screen(w, h);
        send_idle_pct    = idle_pct;
        result_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (hold_midway && i == count / 2)
                drain_results();
            send_pixel_job(make_pixel_job());
        end
        drain_results();
        send_idle_pct    = 0;
        result_stall_pct = 0;
    endtask

    // Random traffic over a spread of screen sizes. The idle mixes cover a
    // free running stretch, a sparse sender, a slow receiver and both at
    // once, so that gaps fall on the read and the write-back cycles alike.
    task automatic test_random_traffic();
        run_traffic_phase(10'd320,  10'd200,  0,  0,  350, 1'b0);
        run_traffic_phase(10'd512,  10'd512,  69, 0,  350, 1'b0);
        run_traffic_phase(10'd1,    10'd1,    0,  69, 250, 1'b0);
        run_traffic_phase(10'd1023, 10'd1023, 27, 27, 250, 1'b1);
        run_traffic_phase(10'd16,   10'd8,    27, 27, 300, 1'b0);
        run_traffic_phase(10'd100,  10'd64,   69, 69, 250, 1'b0);
        run_traffic_phase(10'd0,    10'd512,  27, 27, 40,  1'b0);
        run_traffic_phase(10'd512,  10'd128,  0,  69, 260, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Every input is known from time zero. The bench planes start
        // cleared and the registers at their reset values, as the store
        // will be once its clearing pass is over.
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_WIDTH;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.data       = '0;
        out_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        result_stall_pct = 0;
        n_errors         = 0;
        results_checked  = 0;
        jobs_sent        = 0;
        n_out_of_range   = 0;
        n_matched        = 0;
        cfg_width        = 32'(WIDTH_RESET);
        cfg_height       = 32'(HEIGHT_RESET);
        foreach (cmd_count[i])
            cmd_count[i] = 0;
        foreach (pix_visual[i])
        begin
            pix_visual[i]   = 8'h00;
            pix_priority[i] = 8'h00;
            pix_control[i]  = 8'h00;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first transaction waits out the clearing pass on its own,
        // since in_ch.ready stays low until every word is zero.
        test_reset_defaults();
        test_plane_ops();
        test_screen_geometry();
        test_random_traffic();

        $display("Summary: %0d command transactions (put %0d, read %0d, fill %0d, dither %0d)",
                 jobs_sent, cmd_count[CMD_PUT], cmd_count[CMD_READ],
                 cmd_count[CMD_FILL], cmd_count[CMD_DITHER]);
        $display("Summary: %0d results checked, %0d out of range, %0d probes matched, %0d errors",
                 results_checked, n_out_of_range, n_matched, n_errors);
        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Hard limit on the run in case the store stops answering.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results still owed", expected_pixels.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== three_plane_pixel_store_top.f =====
rtl/tpps_pkg.sv
rtl/tpps_if.sv
rtl/tpps_queue.sv
rtl/tpps_front.sv
rtl/tpps_back.sv
rtl/three_plane_pixel_store_top.sv
bench/tb_top.sv
